### src/ppng_pkg.sv
// ============================================================================
// ppng_pkg
// Shared types, codes and the logarithmic pressure curve for the pad note gate.
// ============================================================================
package ppng_pkg;

  localparam int NUM_PADS_DEF = 16;
  localparam int CURVE_BASE   = 10;
  localparam int LOG_FRAC     = 28;
  localparam int MAX_SLOTS    = 16;

  typedef enum logic [1:0] {
    PAD_OFF       = 2'd0,
    PAD_HELD      = 2'd1,
    PAD_RELEASING = 2'd2
  } pad_mode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TRIGGER = 2'd1,
    EV_RELEASE = 2'd2,
    EV_ENDED   = 2'd3
  } note_event_t;

  localparam logic [0:0] CFG_THRESHOLD = 1'b0;
  localparam logic [0:0] CFG_GAIN      = 1'b1;

  localparam logic [7:0]  THRESHOLD_RST = 8'd16;
  localparam logic [16:0] GAIN_RST      = 17'd32768;
  localparam logic [16:0] GAIN_UNITY    = 17'd65536;

  typedef struct packed {
    logic [3:0] pad_index;
    logic [7:0] pressure;
    logic       envelope_done;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  pad_out;
    logic [1:0]  note_event;
    logic [15:0] level;
    logic [1:0]  pad_state;
  } out_word_t;

  function automatic logic [63:0] fixed_log2(input logic [31:0] x);
    int          top;
    logic [63:0] m;
    logic [63:0] r;
    top = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        top = i;
      end
    end
    m = 64'(x) << (30 - top);
    r = 64'(top) << LOG_FRAC;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r = r | (64'd1 << (LOG_FRAC - i));
      end
    end
    if (x == 32'd0) begin
      r = 64'd0;
    end
    return r;
  endfunction

  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [255:0][15:0] build_curve(input int base);
    logic [255:0][15:0] rom;
    logic [63:0]        l0;
    logic [63:0]        den;
    logic [63:0]        num;
    logic [63:0]        q;
    l0  = fixed_log2(32'd255);
    den = fixed_log2(32'(255 * base)) - l0;
    for (int v = 0; v < 256; v++) begin
      num = fixed_log2(32'(255 + v * (base - 1))) - l0;
      q   = (den != 64'd0) ? long_div((num << 16) + (den >> 1), den) : 64'd0;
      if (q > 64'd65535) begin
        q = 64'd65535;
      end
      rom[v] = q[15:0];
    end
    return rom;
  endfunction

  localparam logic [255:0][15:0] CURVE_ROM = build_curve(CURVE_BASE);

endpackage

### src/ppng_in_reg.sv
// ============================================================================
// ppng_in_reg
// Input register stage that holds one accepted word until the pad engine takes it.
// ============================================================================
module ppng_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppng_pkg::in_word_t in_word,
  input  logic               take,
  output logic               hold_valid,
  output ppng_pkg::in_word_t hold_word
);
  import ppng_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     accept;

  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign hold_valid = valid_r;
  assign hold_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
  end

endmodule

### src/ppng_pad_engine.sv
// ============================================================================
// ppng_pad_engine
// Per-pad state and smoothed level, with the gate logic and the smoothing update.
// ============================================================================
module ppng_pad_engine #(
  parameter int NUM_PADS = ppng_pkg::NUM_PADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  ppng_pkg::in_word_t  item,
  input  logic [7:0]          threshold,
  input  logic [16:0]         gain,
  output ppng_pkg::out_word_t result
);
  import ppng_pkg::*;

  localparam int PAD_SLOTS = (NUM_PADS < MAX_SLOTS) ? NUM_PADS : MAX_SLOTS;
  localparam int IDX_W     = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

  pad_mode_t   mode_r [PAD_SLOTS];
  logic [15:0] lvl_r  [PAD_SLOTS];

  logic               pad_ok;
  logic [IDX_W-1:0]   idx;
  pad_mode_t          cur_mode;
  logic [15:0]        prev_lvl;
  logic [15:0]        target;
  logic [16:0]        g_eff;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [35:0] acc;
  logic [15:0]        smoothed;
  pad_mode_t          new_mode;
  note_event_t        new_event;
  logic [15:0]        out_lvl;
  logic [15:0]        store_lvl;

  assign pad_ok = 32'(item.pad_index) < NUM_PADS;
  assign idx    = item.pad_index[IDX_W-1:0];

  always_comb begin
    cur_mode = PAD_OFF;
    prev_lvl = '0;
    if (pad_ok) begin
      cur_mode = mode_r[idx];
      prev_lvl = lvl_r[idx];
    end
  end

  assign target   = CURVE_ROM[item.pressure];
  assign g_eff    = gain[16] ? GAIN_UNITY : gain;
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, prev_lvl});
  assign prod     = diff * $signed({1'b0, g_eff});
  assign acc      = $signed({4'b0, prev_lvl, 16'b0}) + 36'(prod) + 36'sd32768;
  assign smoothed = acc[31:16];

  always_comb begin
    new_mode  = PAD_OFF;
    new_event = EV_NONE;
    out_lvl   = '0;
    store_lvl = prev_lvl;
    if (pad_ok) begin
      if (cur_mode != PAD_HELD && item.pressure > threshold) begin
        new_mode  = PAD_HELD;
        new_event = EV_TRIGGER;
        out_lvl   = smoothed;
        store_lvl = smoothed;
      end else if (cur_mode == PAD_HELD) begin
        if (item.pressure < threshold) begin
          new_mode  = PAD_RELEASING;
          new_event = EV_RELEASE;
          out_lvl   = prev_lvl;
          store_lvl = '0;
        end else begin
          new_mode  = PAD_HELD;
          out_lvl   = smoothed;
          store_lvl = smoothed;
        end
      end else if (cur_mode == PAD_RELEASING) begin
        if (item.envelope_done) begin
          new_mode  = PAD_OFF;
          new_event = EV_ENDED;
        end else begin
          new_mode = PAD_RELEASING;
        end
      end else begin
        new_mode = PAD_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_SLOTS; i++) begin
        mode_r[i] <= PAD_OFF;
        lvl_r[i]  <= '0;
      end
    end else if (commit && pad_ok) begin
      mode_r[idx] <= new_mode;
      lvl_r[idx]  <= store_lvl;
    end
  end

  always_comb begin
    result.pad_out    = item.pad_index;
    result.note_event = new_event;
    result.level      = out_lvl;
    result.pad_state  = new_mode;
  end

endmodule

### src/pressure_pad_note_gate_core.sv
// ============================================================================
// pressure_pad_note_gate_core
// Note gate for a bank of pressure pads with log-curved, smoothed levels.
// ============================================================================
// The block takes one word per clock while the output side is not stalled and
// returns exactly one result word for each, in order: the word is held in the
// input register, then the curve lookup, the single smoothing multiply and the
// per-pad state update happen combinationally into the output register. Words
// for the same pad may follow each other back to back, since each pad's state
// is rewritten in the cycle its word leaves the input register. Pad state is
// cleared by reset directly; there is no clearing pass.
module pressure_pad_note_gate_core #(
  parameter int NUM_PADS = ppng_pkg::NUM_PADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppng_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ppng_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [16:0]         cfg_wdata
);
  import ppng_pkg::*;

  logic        hold_valid;
  in_word_t    hold_word;
  logic        take;
  out_word_t   result;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_word_t   out_word_r;
  logic [7:0]  threshold_r;
  logic [7:0]  threshold_nxt;
  logic [16:0] gain_r;
  logic [16:0] gain_nxt;

  assign take = hold_valid && (!out_valid_r || !out_stall);

  ppng_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .take      (take),
    .hold_valid(hold_valid),
    .hold_word (hold_word)
  );

  ppng_pad_engine #(
    .NUM_PADS(NUM_PADS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (take),
    .item     (hold_word),
    .threshold(threshold_r),
    .gain     (gain_r),
    .result   (result)
  );

  always_comb begin
    threshold_nxt = threshold_r;
    gain_nxt      = gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold_nxt = cfg_wdata[7:0];
        CFG_GAIN:      gain_nxt      = cfg_wdata;
        default: begin
          threshold_nxt = threshold_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      gain_r      <= GAIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      threshold_r <= threshold_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
